>>> sv/bgpc_pkg.sv
`default_nettype none

package bgpc_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int STORE_BYTES = (MAX_SIDE * MAX_SIDE + 7) / 8;

    localparam int REQ_W     = 2;
    localparam int COORD_W   = 6;
    localparam int SIDE_W    = 7;
    localparam int BIDX_W    = 9;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 13;
    localparam int CELLS_W   = 14;
    localparam int LIN_W     = 13;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_MERGE  = 2'd2,
        REQ_INVERT = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    function automatic logic [3:0] pop8(input logic [BYTE_W-1:0] b);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            s = s + 4'(b[i]);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/bgpc_item_if.sv
`default_nettype none

interface bgpc_item_if;
    logic                                valid;
    logic                                ready;
    logic [bgpc_pkg::REQ_W-1:0]          req_type;
    logic [bgpc_pkg::COORD_W-1:0]        col;
    logic [bgpc_pkg::COORD_W-1:0]        row;
    logic                                write_value;
    logic [bgpc_pkg::BIDX_W-1:0]         byte_index;
    logic [bgpc_pkg::BYTE_W-1:0]         merge_byte;

    modport source (output valid, req_type, col, row, write_value, byte_index, merge_byte,
                    input ready);
    modport sink (input valid, req_type, col, row, write_value, byte_index, merge_byte,
                  output ready);
endinterface

`default_nettype wire

>>> sv/bgpc_result_if.sv
`default_nettype none

interface bgpc_result_if;
    logic                           valid;
    logic                           ready;
    logic                           read_bit;
    logic [bgpc_pkg::COUNT_W-1:0]   set_count;
    logic                           range_error;

    modport source (output valid, read_bit, set_count, range_error, input ready);
    modport sink (input valid, read_bit, set_count, range_error, output ready);
endinterface

`default_nettype wire

>>> sv/bgpc_mem.sv
`default_nettype none

module bgpc_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire logic                         i_clk,
    input  wire bgpc_pkg::t_mem_ctl           i_ctl,
    input  wire logic [ADDR_W-1:0]            i_rd_addr,
    input  wire logic [ADDR_W-1:0]            i_wr_addr,
    input  wire logic [bgpc_pkg::BYTE_W-1:0]  i_wr_data,
    output logic      [bgpc_pkg::BYTE_W-1:0]  o_rd_data
);

    logic [bgpc_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [bgpc_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> sv/bgpc_ctrl.sv
`default_nettype none

module bgpc_ctrl #(
    parameter int MAX_SIDE    = 64,
    parameter int STORE_BYTES = 512,
    parameter int ADDR_W      = 9,
    parameter int CNT_W       = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bgpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bgpc_pkg::SIDE_W-1:0]       i_cfg_data,
    bgpc_item_if.sink                              i_item,
    bgpc_result_if.source                          o_result,
    output bgpc_pkg::t_mem_ctl                     o_mem_ctl,
    output logic [ADDR_W-1:0]                      o_rd_addr,
    output logic [ADDR_W-1:0]                      o_wr_addr,
    output logic [bgpc_pkg::BYTE_W-1:0]            o_wr_data,
    input  wire logic [bgpc_pkg::BYTE_W-1:0]       i_rd_data
);

    localparam int SIDE_W  = bgpc_pkg::SIDE_W;
    localparam int COUNT_W = bgpc_pkg::COUNT_W;
    localparam int CELLS_W = bgpc_pkg::CELLS_W;
    localparam int LIN_W   = bgpc_pkg::LIN_W;
    localparam int BYTE_W  = bgpc_pkg::BYTE_W;
    localparam int SIDE_RST = (64 > MAX_SIDE) ? MAX_SIDE : 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_INVERT,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic                       r_clr;
    logic [ADDR_W-1:0]          r_clr_ptr;
    logic [SIDE_W-1:0]          r_width;
    logic [SIDE_W-1:0]          r_height;
    logic [CELLS_W-1:0]         r_cells;
    logic [CNT_W-1:0]           r_used;
    logic [COUNT_W-1:0]         r_count;
    bgpc_pkg::t_req             r_req;
    logic                       r_wval;
    logic [BYTE_W-1:0]          r_merge;
    logic [bgpc_pkg::BIDX_W-1:0] r_bidx;
    logic [LIN_W-1:0]           r_k;
    logic                       r_res_bit;
    logic                       r_res_err;
    logic [CNT_W-1:0]           r_inv_ptr;
    logic                       r_inv_pend;
    logic [ADDR_W-1:0]          r_inv_addr;
    logic                       r_out_valid;
    logic                       r_out_bit;
    logic [COUNT_W-1:0]         r_out_count;
    logic                       r_out_err;

    logic [CELLS_W-1:0]         n_cells;
    logic [SIDE_W-1:0]          cfg_side;
    logic                       accept;
    logic                       rw_err;
    logic                       mg_err;
    logic [LIN_W-1:0]           n_k;
    logic [LIN_W-4:0]           k_byte;
    logic                       byte_oob;
    logic [ADDR_W-1:0]          cur_addr;
    logic [2:0]                 sh;
    logic                       old_bit;
    logic [BYTE_W-1:0]          bit_mask;
    logic [BYTE_W-1:0]          wr_byte;
    logic [BYTE_W-1:0]          merge_new;
    logic [COUNT_W-1:0]         merge_count;
    logic                       inv_rd;
    logic                       inv_last;
    logic [2:0]                 tail;
    logic [BYTE_W-1:0]          inv_mask;

    assign n_cells  = CELLS_W'(r_width) * CELLS_W'(r_height);
    assign cfg_side = (i_cfg_data == '0) ? SIDE_W'(1)
                    : (32'(i_cfg_data) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : i_cfg_data;

    assign i_item.ready = (r_state == S_IDLE) && !r_clr;
    assign accept       = i_item.valid && i_item.ready;

    assign rw_err = ({1'b0, i_item.col} >= r_width) || ({1'b0, i_item.row} >= r_height);
    assign mg_err = (32'(i_item.byte_index) >= 32'(r_used))
                 || (32'(i_item.byte_index) >= STORE_BYTES);
    assign n_k    = LIN_W'(LIN_W'(i_item.row) * LIN_W'(r_width) + LIN_W'(i_item.col));

    assign k_byte   = r_k[LIN_W-1:3];
    assign byte_oob = (r_req != bgpc_pkg::REQ_MERGE) && (32'(k_byte) >= STORE_BYTES);
    assign cur_addr = (r_req == bgpc_pkg::REQ_MERGE) ? ADDR_W'(r_bidx) : ADDR_W'(k_byte);

    // single cell and byte merge arithmetic
    assign sh          = r_k[2:0];
    assign old_bit     = i_rd_data[sh];
    assign bit_mask    = BYTE_W'(1) << sh;
    assign wr_byte     = r_wval ? (i_rd_data | bit_mask) : (i_rd_data & ~bit_mask);
    assign merge_new   = i_rd_data & r_merge;
    assign merge_count = r_count - COUNT_W'(bgpc_pkg::pop8(i_rd_data))
                       + COUNT_W'(bgpc_pkg::pop8(merge_new));

    // invert walk, padding bits of the last byte stay clear
    assign inv_rd   = r_inv_ptr < r_used;
    assign inv_last = CNT_W'(r_inv_addr) == (r_used - CNT_W'(1));
    assign tail     = r_cells[2:0];
    assign inv_mask = (inv_last && (tail != '0)) ? (8'hFF >> (3'(4'd8 - {1'b0, tail})))
                                                 : 8'hFF;

    always_comb begin
        o_mem_ctl = '0;
        o_rd_addr = '0;
        o_wr_addr = '0;
        o_wr_data = '0;
        if (r_clr) begin
            o_mem_ctl.wr_en = 1'b1;
            o_wr_addr       = r_clr_ptr;
        end
        case (r_state)
            S_READ: begin
                o_mem_ctl.rd_en = !byte_oob;
                o_rd_addr       = cur_addr;
            end
            S_MODIFY: begin
                o_mem_ctl.wr_en = (r_req == bgpc_pkg::REQ_WRITE)
                               || (r_req == bgpc_pkg::REQ_MERGE);
                o_wr_addr       = cur_addr;
                o_wr_data       = (r_req == bgpc_pkg::REQ_MERGE) ? merge_new : wr_byte;
            end
            S_INVERT: begin
                o_mem_ctl.rd_en = inv_rd;
                o_rd_addr       = r_inv_ptr[ADDR_W-1:0];
                o_mem_ctl.wr_en = r_inv_pend;
                o_wr_addr       = r_inv_addr;
                o_wr_data       = ~i_rd_data & inv_mask;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr       <= 1'b1;
            r_clr_ptr   <= '0;
            r_width     <= SIDE_W'(SIDE_RST);
            r_height    <= SIDE_W'(SIDE_RST);
            r_count     <= '0;
            r_inv_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cells <= n_cells;
            r_used  <= CNT_W'((n_cells + CELLS_W'(7)) >> 3);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bgpc_pkg::CFG_GRID_WIDTH:  r_width  <= cfg_side;
                    bgpc_pkg::CFG_GRID_HEIGHT: r_height <= cfg_side;
                endcase
                r_clr     <= 1'b1;
                r_clr_ptr <= '0;
                r_count   <= '0;
            end else if (r_clr) begin
                if (r_clr_ptr == ADDR_W'(STORE_BYTES - 1)) begin
                    r_clr <= 1'b0;
                end else begin
                    r_clr_ptr <= r_clr_ptr + ADDR_W'(1);
                end
            end

            if (o_result.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req     <= bgpc_pkg::t_req'(i_item.req_type);
                        r_wval    <= i_item.write_value;
                        r_merge   <= i_item.merge_byte;
                        r_bidx    <= i_item.byte_index;
                        r_k       <= n_k;
                        r_res_bit <= 1'b0;
                        case (bgpc_pkg::t_req'(i_item.req_type)) inside
                            bgpc_pkg::REQ_READ, bgpc_pkg::REQ_WRITE: begin
                                r_res_err <= rw_err;
                                r_state   <= rw_err ? S_DONE : S_READ;
                            end
                            bgpc_pkg::REQ_MERGE: begin
                                r_res_err <= mg_err;
                                r_state   <= mg_err ? S_DONE : S_READ;
                            end
                            default: begin
                                r_res_err  <= 1'b0;
                                r_inv_ptr  <= '0;
                                r_inv_pend <= 1'b0;
                                r_state    <= S_INVERT;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (byte_oob) begin
                        r_res_err <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_MODIFY;
                    end
                end
                S_MODIFY: begin
                    case (r_req)
                        bgpc_pkg::REQ_READ: r_res_bit <= old_bit;
                        bgpc_pkg::REQ_WRITE: begin
                            if (old_bit != r_wval) begin
                                r_count <= r_wval ? r_count + COUNT_W'(1)
                                                  : r_count - COUNT_W'(1);
                            end
                        end
                        default: r_count <= merge_count;
                    endcase
                    r_state <= S_DONE;
                end
                S_INVERT: begin
                    if (inv_rd) begin
                        r_inv_ptr  <= r_inv_ptr + CNT_W'(1);
                        r_inv_addr <= r_inv_ptr[ADDR_W-1:0];
                        r_inv_pend <= 1'b1;
                    end else begin
                        r_inv_pend <= 1'b0;
                        if (!r_inv_pend) begin
                            r_count <= COUNT_W'(r_cells) - r_count;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_bit   <= r_res_bit;
                        r_out_count <= r_count;
                        r_out_err   <= r_res_err;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.read_bit    = r_out_bit;
    assign o_result.set_count   = r_out_count;
    assign o_result.range_error = r_out_err;

endmodule

`default_nettype wire

>>> sv/bit_grid_with_population_count.sv
// a read, write or and-merge item passes S_READ and S_MODIFY before S_DONE loads its result,
// an item whose column, row or byte index is out of range goes straight to S_DONE, and
// invert-all walks all used bytes in S_INVERT first; only one item is in flight, and the
// next item waits until the output register is loaded, which a held result can stall
// the byte store sits in one memory (one read, one write port) and each write, merge or
// invert is a read-modify-write; reset and every register write start a clearing pass over
// all (MAX_SIDE*MAX_SIDE+7)/8 bytes (512 at the default) during which no item is accepted
`default_nettype none

module bit_grid_with_population_count (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bgpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bgpc_pkg::SIDE_W-1:0]       i_cfg_data,
    bgpc_item_if.sink                              i_item,
    bgpc_result_if.source                          o_result
);

    localparam int MAX_SIDE    = bgpc_pkg::MAX_SIDE;
    localparam int STORE_BYTES = bgpc_pkg::STORE_BYTES;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);

    bgpc_pkg::t_mem_ctl               mem_ctl;
    logic [ADDR_W-1:0]                rd_addr;
    logic [ADDR_W-1:0]                wr_addr;
    logic [bgpc_pkg::BYTE_W-1:0]      wr_data;
    logic [bgpc_pkg::BYTE_W-1:0]      rd_data;

    bgpc_ctrl #(
        .MAX_SIDE    (MAX_SIDE),
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .o_result   (o_result),
        .o_mem_ctl  (mem_ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .i_rd_data  (rd_data)
    );

    bgpc_mem #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> sv/bgpc_checker.sv
`default_nettype none

module bgpc_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_cfg_we,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic                             i_read_bit,
    input wire logic [bgpc_pkg::COUNT_W-1:0]     i_set_count,
    input wire logic                             i_range_error
);

    // clearing pass follows reset
    a_reset_blocks: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("item port ready right after reset");

    // a register write starts a clearing pass
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_in_ready)
        else $error("item port ready right after a register write");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second item taken while one is in flight");

    a_err_no_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_range_error) |-> !i_read_bit)
        else $error("read bit set on a range error");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_set_count) && $stable(i_range_error)
             && $stable(i_read_bit)))
        else $error("stalled result changed");

endmodule

bind bit_grid_with_population_count bgpc_checker u_bgpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_read_bit    (o_result.read_bit),
    .i_set_count   (o_result.set_count),
    .i_range_error (o_result.range_error)
);

`default_nettype wire
